>>> rtl/lps_pkg.sv
// Shared types, constants and register codes of the line pixel stepper.
package lps_pkg;

  // Coordinate width of the endpoint fields.
  localparam int COORD_BITS = 12;
  // Position width: one sign bit of headroom for differences.
  localparam int POS_W = COORD_BITS + 1;
  // Error accumulator width: holds up to three times the major span.
  localparam int ERR_W = COORD_BITS + 4;

  localparam int CFG_W       = 11;
  localparam int INDEX_W     = 20;
  localparam int COLOR_W     = 32;
  localparam int REG_IDX_W   = 1;

  // Default clamp for the buffer sides.
  localparam int MAX_SIDE_DEFAULT = 1024;

  // Reset values of the buffer registers.
  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(320);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(240);

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_BUFFER_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_BUFFER_HEIGHT = 1'b1;

  // Item opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // One input beat.
  typedef struct packed {
    logic                         opcode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_W-1:0]           pen_color;
  } item_t;

  // One output beat.
  typedef struct packed {
    logic               write_enable;
    logic [INDEX_W-1:0] pixel_index;
    logic [COLOR_W-1:0] pixel_color;
    logic               last;
  } result_t;

  // Line state prepared from a load beat.
  typedef struct packed {
    logic                         steep;
    logic signed [POS_W-1:0]      major_pos;
    logic signed [COORD_BITS-1:0] major_end;
    logic signed [POS_W-1:0]      minor_pos;
    logic                         minor_up;
    logic signed [POS_W-1:0]      major_span;
    logic signed [ERR_W-1:0]      error_step;
    logic [COLOR_W-1:0]           color;
  } line_setup_t;

  // Pixel produced by one step, before clipping and addressing.
  typedef struct packed {
    logic                    hit;
    logic signed [POS_W-1:0] row;
    logic signed [POS_W-1:0] col;
    logic                    last;
    logic [COLOR_W-1:0]      color;
  } step_info_t;

endpackage

>>> rtl/lps_setup.sv
// Load path: axis swap, endpoint ordering and error term setup.
module lps_setup (
  input  lps_pkg::item_t       item,
  output lps_pkg::line_setup_t setup
);

  localparam int C = lps_pkg::COORD_BITS;
  localparam int P = lps_pkg::POS_W;
  localparam int E = lps_pkg::ERR_W;

  logic signed [C-1:0] ax, ay, bx, by;
  logic signed [P-1:0] dx, dy, adx, ady;
  logic                steep;
  logic signed [C-1:0] maj_a, min_a, maj_b, min_b;
  logic signed [C-1:0] s_maj_a, s_min_a, s_maj_b, s_min_b;
  logic                swap;
  logic signed [P-1:0] dmin, admin;

  assign ax = item.start_x;
  assign ay = item.start_y;
  assign bx = item.end_x;
  assign by = item.end_y;

  // Spans on both axes; steep when the row span is strictly larger.
  always_comb begin
    dx    = P'(ax) - P'(bx);
    dy    = P'(ay) - P'(by);
    adx   = dx[P-1] ? -dx : dx;
    ady   = dy[P-1] ? -dy : dy;
    steep = $unsigned(adx) < $unsigned(ady);
  end

  // Swap axes for steep lines, then order by the major coordinate.
  always_comb begin
    maj_a = steep ? ay : ax;
    min_a = steep ? ax : ay;
    maj_b = steep ? by : bx;
    min_b = steep ? bx : by;
    swap  = maj_a > maj_b;
    s_maj_a = swap ? maj_b : maj_a;
    s_min_a = swap ? min_b : min_a;
    s_maj_b = swap ? maj_a : maj_b;
    s_min_b = swap ? min_a : min_b;
  end

  // Doubled minor span and the starting line state.
  always_comb begin
    dmin  = P'(s_min_b) - P'(s_min_a);
    admin = dmin[P-1] ? -dmin : dmin;
    setup.steep      = steep;
    setup.major_pos  = P'(s_maj_a);
    setup.major_end  = s_maj_b;
    setup.minor_pos  = P'(s_min_a);
    setup.minor_up   = s_min_b > s_min_a;
    setup.major_span = P'(s_maj_b) - P'(s_maj_a);
    setup.error_step = E'({admin, 1'b0});
    setup.color      = item.pen_color;
  end

endmodule

>>> rtl/lps_walker.sv
// Line state registers and the per-step Bresenham update.
module lps_walker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 beat,
  input  logic                 opcode,
  input  lps_pkg::line_setup_t setup,
  output lps_pkg::step_info_t  info
);

  localparam int C = lps_pkg::COORD_BITS;
  localparam int P = lps_pkg::POS_W;
  localparam int E = lps_pkg::ERR_W;

  logic                          line_active;
  logic                          is_steep;
  logic signed [P-1:0]           major_pos;
  logic signed [C-1:0]           major_end;
  logic signed [P-1:0]           minor_pos;
  logic                          minor_up;
  logic signed [P-1:0]           major_span;
  logic signed [E-1:0]           error_step;
  logic signed [E-1:0]           error_acc;
  logic [lps_pkg::COLOR_W-1:0]   held_color;

  logic                last_pos;
  logic signed [E-1:0] acc_sum;
  logic                bump;
  logic signed [E-1:0] acc_next;
  logic signed [P-1:0] minor_next;
  logic                step_hit;

  // Pixel at the current position and the next error and minor values.
  always_comb begin
    last_pos   = major_pos >= P'(major_end);
    acc_sum    = error_acc + error_step;
    bump       = acc_sum > E'(major_span);
    acc_next   = bump ? acc_sum - (E'(major_span) <<< 1) : acc_sum;
    minor_next = bump ? (minor_up ? minor_pos + P'(1) : minor_pos - P'(1)) : minor_pos;
    step_hit   = (opcode == lps_pkg::OP_STEP) && line_active;
    info.hit   = step_hit;
    info.row   = is_steep ? major_pos : minor_pos;
    info.col   = is_steep ? minor_pos : major_pos;
    info.last  = last_pos;
    info.color = held_color;
  end

  // State update on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (beat) begin
      if (opcode == lps_pkg::OP_LOAD) begin
        line_active <= 1'b1;
        is_steep    <= setup.steep;
        major_pos   <= setup.major_pos;
        major_end   <= setup.major_end;
        minor_pos   <= setup.minor_pos;
        minor_up    <= setup.minor_up;
        major_span  <= setup.major_span;
        error_step  <= setup.error_step;
        error_acc   <= '0;
        held_color  <= setup.color;
      end else if (line_active) begin
        error_acc <= acc_next;
        minor_pos <= minor_next;
        if (last_pos) begin
          line_active <= 1'b0;
        end else begin
          major_pos <= major_pos + P'(1);
        end
      end
    end
  end

endmodule

>>> rtl/lps_addr.sv
// Clipping, pixel address and the output register.
module lps_addr #(
  parameter int MAX_SIDE = lps_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       beat,
  input  lps_pkg::step_info_t        info,
  input  logic [lps_pkg::CFG_W-1:0]  buffer_width,
  input  logic [lps_pkg::CFG_W-1:0]  buffer_height,
  output logic                       take,
  output logic                       result_valid,
  input  logic                       result_stall,
  output lps_pkg::result_t           result
);

  localparam int C      = lps_pkg::COORD_BITS;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int PROD_W = C + SIDE_W;

  logic [SIDE_W-1:0]    w_side, h_side;
  logic [C-1:0]         row_mag, col_mag;
  logic                 in_bounds;
  logic [PROD_W-1:0]    addr;
  lps_pkg::result_t     result_next;

  // Buffer sides saturated to the largest supported side.
  always_comb begin
    w_side = (32'(buffer_width) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(buffer_width);
    h_side = (32'(buffer_height) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(buffer_height);
  end

  // Clip test and row-major address of the step pixel.
  always_comb begin
    row_mag   = info.row[C-1:0];
    col_mag   = info.col[C-1:0];
    in_bounds = !info.row[C] && !info.col[C] &&
                (32'(row_mag) < 32'(h_side)) && (32'(col_mag) < 32'(w_side));
    addr      = PROD_W'(row_mag) * PROD_W'(w_side) + PROD_W'(col_mag);
    result_next = '0;
    if (info.hit) begin
      result_next.write_enable = in_bounds;
      result_next.pixel_index  = in_bounds ? lps_pkg::INDEX_W'(addr) : '0;
      result_next.pixel_color  = info.color;
      result_next.last         = info.last;
    end
  end

  // The register loads whenever it is empty or its beat is leaving.
  assign take = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (take && beat) begin
      result <= result_next;
    end
  end

endmodule

>>> rtl/line_pixel_stepper_top.sv
// Top level of the line pixel stepper: configuration registers and datapath.
//
// Bresenham line rasterizer. A load beat (opcode load) takes two endpoints
// and a color and sets up a new line; each step beat then yields the pixel
// at the next major-axis position as a write enable, a row-major pixel
// index, the color and a last mark. Every accepted beat gives exactly one
// result beat; loads and steps with no active line give an all-zero result.
// Channels: item_valid/item_stall/item in, result_valid/result_stall/result
// out; a beat moves when valid is high and stall is low. The buffer width
// and height are written through cfg_valid/cfg_ready/cfg_index/cfg_data,
// which is always ready; write them only while the block is idle.
// Each accepted item's result appears in the next cycle; one item is taken
// every cycle unless the output stalls: the line state update is a single
// add and compare and the address is one multiply-add ahead of the output
// register. While the result register holds a stalled beat, item_stall is
// raised. A synchronous reset empties the output register, ends any active
// line and sets the buffer to 320 by 240.
module line_pixel_stepper_top #(
  parameter int MAX_SIDE = lps_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  lps_pkg::item_t                    item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output lps_pkg::result_t                  result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lps_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [lps_pkg::CFG_W-1:0]         cfg_data
);

  logic [lps_pkg::CFG_W-1:0] buffer_width;
  logic [lps_pkg::CFG_W-1:0] buffer_height;
  logic                      take;
  logic                      beat;
  lps_pkg::line_setup_t      setup;
  lps_pkg::step_info_t       info;

  // Configuration writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_width  <= lps_pkg::WIDTH_RESET;
      buffer_height <= lps_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lps_pkg::REG_BUFFER_WIDTH:  buffer_width  <= cfg_data;
        lps_pkg::REG_BUFFER_HEIGHT: buffer_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input handshake follows the output register.
  assign item_stall = !take;
  assign beat       = item_valid && take;

  lps_setup u_setup (
    .item  (item),
    .setup (setup)
  );

  lps_walker u_walker (
    .clk    (clk),
    .rst    (rst),
    .beat   (beat),
    .opcode (item.opcode),
    .setup  (setup),
    .info   (info)
  );

  lps_addr #(
    .MAX_SIDE (MAX_SIDE)
  ) u_addr (
    .clk           (clk),
    .rst           (rst),
    .beat          (beat),
    .info          (info),
    .buffer_width  (buffer_width),
    .buffer_height (buffer_height),
    .take          (take),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

endmodule
